// ===== rtl/fmtq_pkg.sv =====
package fmtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_CALC_W = PTR_W + 1;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 2 * BYTE_W;
    localparam int FILL_W      = 4;

    localparam logic [PTR_W-1:0]       PTR_LAST    = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_CALC_W-1:0] DEPTH_EXT   = FILL_CALC_W'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0]      FILL_MAX    = '1;
    localparam logic [BYTE_W-1:0]      FRAME_START = 8'hAA;

    localparam logic REQ_POST = 1'b0;
    localparam logic REQ_DONE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] var_id;
        logic [BYTE_W-1:0] var_value;
    } req_t;

    typedef struct packed {
        logic              launch;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_value;
        logic [BYTE_W-1:0] frame_check;
        logic              dropped;
        logic [FILL_W-1:0] fill_level;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } sts_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_LAST) begin
            r = '0;
        end
        else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/fmtq_req_if.sv =====
interface fmtq_req_if;
    import fmtq_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] var_id;
    logic [BYTE_W-1:0] var_value;

    modport source (output valid, req_type, var_id, var_value, input ready);
    modport sink   (input valid, req_type, var_id, var_value, output ready);
endinterface

// ===== rtl/fmtq_rsp_if.sv =====
interface fmtq_rsp_if;
    import fmtq_pkg::*;

    logic              valid;
    logic              ready;
    logic              launch;
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_value;
    logic [BYTE_W-1:0] frame_check;
    logic              dropped;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, launch, start_byte, frame_id, frame_value, frame_check,
                    dropped, fill_level, input ready);
    modport sink   (input valid, launch, start_byte, frame_id, frame_value, frame_check,
                    dropped, fill_level, output ready);
endinterface

// ===== rtl/fmtq_ctrl.sv =====
module fmtq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           rsp_ready,
    input  fmtq_pkg::sts_t sts,
    output fmtq_pkg::cmd_t cmd,
    output logic           req_ready
);
    import fmtq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // output register free or draining this cycle
                if (!sts.out_busy || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/fmtq_dp.sv =====
module fmtq_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  fmtq_pkg::cmd_t cmd,
    input  fmtq_pkg::req_t req,
    input  logic           rsp_ready,
    output fmtq_pkg::sts_t sts,
    output logic           rsp_valid,
    output fmtq_pkg::rsp_t rsp
);
    import fmtq_pkg::*;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] mem_q_reg;

    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic             idle_reg;
    logic             idle_next;

    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic             wr_en;
    logic             launch_now;
    logic             use_mem_now;
    logic             dropped_now;
    logic [FILL_CALC_W-1:0] fill_calc;
    logic [FILL_W-1:0]      fill_now;

    // per-transaction result held until the output register takes it
    logic              launch_pend_reg;
    logic              use_mem_pend_reg;
    logic              dropped_pend_reg;
    logic [FILL_W-1:0] fill_pend_reg;
    logic [BYTE_W-1:0] byp_id_reg;
    logic [BYTE_W-1:0] byp_value_reg;

    logic              out_valid_reg;
    rsp_t              out_reg;
    rsp_t              out_next;
    logic [BYTE_W-1:0] sel_id;
    logic [BYTE_W-1:0] sel_value;

    assign wp_inc = ptr_inc(wp_reg);
    assign rp_inc = ptr_inc(rp_reg);

    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        idle_next   = idle_reg;
        wr_en       = 1'b0;
        launch_now  = 1'b0;
        use_mem_now = 1'b0;
        dropped_now = 1'b0;
        if (cmd.accept)
        begin
            if (req.req_type == REQ_POST)
            begin
                if (wp_inc == rp_reg)
                begin
                    dropped_now = 1'b1;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wp_next = wp_inc;
                    // idle means empty, so the posted pair is the one launched
                    if (idle_reg)
                    begin
                        idle_next  = 1'b0;
                        launch_now = 1'b1;
                    end
                end
            end
            else if (!idle_reg)
            begin
                rp_next = rp_inc;
                if (wp_reg != rp_inc)
                begin
                    launch_now  = 1'b1;
                    use_mem_now = 1'b1;
                end
                else
                begin
                    idle_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (wp_next >= rp_next)
        begin
            fill_calc = FILL_CALC_W'(wp_next) - FILL_CALC_W'(rp_next);
        end
        else
        begin
            fill_calc = FILL_CALC_W'(wp_next) + DEPTH_EXT - FILL_CALC_W'(rp_next);
        end
        if (fill_calc > FILL_CALC_W'(FILL_MAX))
        begin
            fill_now = FILL_MAX;
        end
        else
        begin
            fill_now = FILL_W'(fill_calc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= {req.var_id, req.var_value};
        end
        if (cmd.accept)
        begin
            mem_q_reg <= mem[rp_inc];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            idle_reg <= 1'b1;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            idle_reg <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            launch_pend_reg  <= launch_now;
            use_mem_pend_reg <= use_mem_now;
            dropped_pend_reg <= dropped_now;
            fill_pend_reg    <= fill_now;
            byp_id_reg       <= req.var_id;
            byp_value_reg    <= req.var_value;
        end
    end

    always_comb
    begin
        sel_id    = use_mem_pend_reg ? mem_q_reg[ENTRY_W-1:BYTE_W] : byp_id_reg;
        sel_value = use_mem_pend_reg ? mem_q_reg[BYTE_W-1:0] : byp_value_reg;
        out_next  = '0;
        out_next.dropped    = dropped_pend_reg;
        out_next.fill_level = fill_pend_reg;
        if (launch_pend_reg)
        begin
            out_next.launch      = 1'b1;
            out_next.start_byte  = FRAME_START;
            out_next.frame_id    = sel_id;
            out_next.frame_value = sel_value;
            out_next.frame_check = FRAME_START ^ sel_id ^ sel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_busy = out_valid_reg;
    assign rsp_valid    = out_valid_reg;
    assign rsp          = out_reg;

endmodule

// ===== rtl/framed_message_tx_queue.sv =====
// channel | role | payload
// --------+------+-------------------------------------------------------------
// req     | sink | req_type, var_id, var_value
// rsp     | src  | launch, start_byte, frame_id, frame_value, frame_check,
//         |      | dropped, fill_level
//
// a request transaction does the pointer update and ring access first,
// then the result moves into the output register
// the registered read port of the ring makes that move a separate step
// a new request is taken once the previous result sits in the output register
// a stalled rsp holds the output register and, if a second result waits, req
// reset empties the ring and marks the transmitter idle; ring contents are not cleared
module framed_message_tx_queue (
    input  logic        clk,
    input  logic        rst_n,
    fmtq_req_if.sink    req,
    fmtq_rsp_if.source  rsp
);
    import fmtq_pkg::*;

    cmd_t cmd;
    sts_t sts;
    req_t req_data;
    rsp_t rsp_data;
    logic rsp_valid;

    assign req_data.req_type  = req.req_type;
    assign req_data.var_id    = req.var_id;
    assign req_data.var_value = req.var_value;

    fmtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd),
        .req_ready (req.ready)
    );

    fmtq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req_data),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp_data)
    );

    assign rsp.valid       = rsp_valid;
    assign rsp.launch      = rsp_data.launch;
    assign rsp.start_byte  = rsp_data.start_byte;
    assign rsp.frame_id    = rsp_data.frame_id;
    assign rsp.frame_value = rsp_data.frame_value;
    assign rsp.frame_check = rsp_data.frame_check;
    assign rsp.dropped     = rsp_data.dropped;
    assign rsp.fill_level  = rsp_data.fill_level;

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one still in flight");

    a_check_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.launch) |->
            (rsp.start_byte == FRAME_START &&
             rsp.frame_check == (FRAME_START ^ rsp.frame_id ^ rsp.frame_value)))
        else $error("launched frame has wrong start or check byte");

    a_drop_no_launch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.launch && rsp.dropped))
        else $error("dropped post also launched a frame");

    a_launch_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.launch) |-> (rsp.fill_level != '0))
        else $error("frame launched with empty ring");

endmodule

// ===== bench/framed_message_tx_queue_test.sv =====
`timescale 1ns / 100ps

module framed_message_tx_queue_test;
    import fmtq_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 10;

    // predicts the launch/drop/fill answer for every accepted request
    class frame_scoreboard;
        logic [ENTRY_W-1:0] ring [QUEUE_DEPTH];
        int unsigned        wr_slot;
        int unsigned        rd_slot;
        bit                 tx_quiet;
        rsp_t               expected_q [$];
        int unsigned        errors;
        int unsigned        n_requests;
        int unsigned        n_launch;
        int unsigned        n_drop;
        int unsigned        n_checked;

        function new();
            wr_slot    = 0;
            rd_slot    = 0;
            tx_quiet   = 1'b1;
            errors     = 0;
            n_requests = 0;
            n_launch   = 0;
            n_drop     = 0;
            n_checked  = 0;
        endfunction

        function rsp_t head_frame();
            rsp_t f;
            f             = '0;
            f.launch      = 1'b1;
            f.start_byte  = FRAME_START;
            f.frame_id    = ring[rd_slot][ENTRY_W-1:BYTE_W];
            f.frame_value = ring[rd_slot][BYTE_W-1:0];
            f.frame_check = FRAME_START ^ f.frame_id ^ f.frame_value;
            return f;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task note_request(input req_t r);
            rsp_t        e;
            int unsigned nxt;
            int unsigned fill;
            e = '0;
            n_requests++;
            if (r.req_type == REQ_POST) begin
                nxt = (wr_slot + 1) % QUEUE_DEPTH;
                if (nxt == rd_slot) begin
                    e.dropped = 1'b1;
                    n_drop++;
                end
                else begin
                    ring[wr_slot] = {r.var_id, r.var_value};
                    wr_slot = nxt;
                    if (tx_quiet) begin
                        tx_quiet = 1'b0;
                        e = head_frame();
                    end
                end
            end
            else if (!tx_quiet) begin
                // done retires the frame in flight
                rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                if (wr_slot != rd_slot) begin
                    e = head_frame();
                end
                else begin
                    tx_quiet = 1'b1;
                end
            end
            if (e.launch) begin
                n_launch++;
            end
            fill = (wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH;
            e.fill_level = (fill > FILL_MAX) ? FILL_MAX : FILL_W'(fill);
            expected_q.push_back(e);
        endtask

        task match_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want) begin
                report($sformatf("result %0d field %s: got %h, expected %h",
                                 n_checked, name, got, want));
            end
        endtask

        task check_result(input rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0) begin
                report("result transaction with nothing expected");
            end
            else begin
                want = expected_q.pop_front();
                match_field("launch", 8'(got.launch), 8'(want.launch));
                match_field("start_byte", got.start_byte, want.start_byte);
                match_field("frame_id", got.frame_id, want.frame_id);
                match_field("frame_value", got.frame_value, want.frame_value);
                match_field("frame_check", got.frame_check, want.frame_check);
                match_field("dropped", 8'(got.dropped), 8'(want.dropped));
                match_field("fill_level", 8'(got.fill_level), 8'(want.fill_level));
                n_checked++;
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    fmtq_req_if req_ch ();
    fmtq_rsp_if rsp_ch ();

    framed_message_tx_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    frame_scoreboard sb;
    int unsigned     gen_fill;
    int unsigned     useful_items;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && req_ch.valid && req_ch.ready) begin
            sb.note_request(req_t'{req_ch.req_type, req_ch.var_id, req_ch.var_value});
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_t'{rsp_ch.launch, rsp_ch.start_byte, rsp_ch.frame_id,
                                   rsp_ch.frame_value, rsp_ch.frame_check,
                                   rsp_ch.dropped, rsp_ch.fill_level});
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned gap_len(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        else if (r < 85) begin
            return $urandom_range(1, 2);
        end
        else if (r < 96) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 50);
    endfunction

    task automatic send_request(input logic kind, input logic [7:0] id,
                                input logic [7:0] value, input bit quiet);
        int unsigned gap;
        gap = gap_len(quiet);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.var_id    <= id;
        req_ch.var_value <= value;
        do @(posedge clk); while (!req_ch.ready);
        // rough occupancy so ignored done transactions are not counted
        if (kind == REQ_POST) begin
            useful_items++;
            if (gen_fill < QUEUE_DEPTH - 1) begin
                gen_fill++;
            end
        end
        else if (gen_fill > 0) begin
            useful_items++;
            gen_fill--;
        end
    endtask

    // response side back-pressure
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                run   = $urandom_range(30, 150);
                stall = 1;
            end
            else begin
                run   = $urandom_range(1, 6);
                r     = $urandom_range(0, 99);
                stall = (r < 60) ? $urandom_range(1, 2) :
                        (r < 90) ? $urandom_range(3, 6) : $urandom_range(10, 40);
            end
            @(posedge clk);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clk);
        end
    end

    initial begin
        #4_000_000;
        $display("** framed_message_tx_queue: FAILED **");
        $finish;
    end

    initial begin
        int unsigned seg_len;
        int unsigned post_pct;
        bit          quiet;
        sb           = new();
        gen_fill     = 0;
        useful_items = 0;
        rst_n             = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_POST;
        req_ch.var_id    <= '0;
        req_ch.var_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // done while idle, fill the ring, overflow, then partial drain
        send_request(REQ_DONE, 8'hFF, 8'hFF, 1'b0);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            send_request(REQ_POST, 8'(k * 17), ~8'(k * 17), 1'b0);
        end
        send_request(REQ_POST, 8'h5A, 8'hA5, 1'b0);
        send_request(REQ_DONE, 8'h00, 8'h00, 1'b0);
        send_request(REQ_POST, 8'hFF, 8'hFF, 1'b0);
        send_request(REQ_POST, 8'h01, 8'h80, 1'b0);
        repeat (5) send_request(REQ_DONE, 8'($urandom), 8'($urandom), 1'b0);

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 80);
            quiet   = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       post_pct = 25;
                1:       post_pct = 50;
                2:       post_pct = 60;
                default: post_pct = 90;
            endcase
            repeat (seg_len) begin
                if ($urandom_range(1, 100) <= post_pct) begin
                    send_request(REQ_POST, 8'($urandom), 8'($urandom), quiet);
                end
                else begin
                    send_request(REQ_DONE, 8'($urandom), 8'($urandom), quiet);
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests accepted: %0d, results checked: %0d", sb.n_requests, sb.n_checked);
        $display("frames launched: %0d, posts dropped on a full ring: %0d, mismatches: %0d",
                 sb.n_launch, sb.n_drop, sb.errors);
        if (sb.errors == 0) begin
            $display("** framed_message_tx_queue: PASSED **");
        end
        else begin
            $display("** framed_message_tx_queue: FAILED **");
        end
        $finish;
    end

endmodule
